[sv/ssm_pkg.sv]
// Shared types and constants for the seed sequence mixer.
// No dependencies; imported by ssm_ctrl, ssm_datapath and seed_sequence_mixer.
package ssm_pkg;

	localparam int unsigned MAX_COUNT = 64;
	localparam int unsigned CNT_W     = $clog2(MAX_COUNT + 1);

	localparam logic [31:0] MUL_STEP = 32'h931e8875;
	localparam logic [31:0] MIX_A    = 32'hca01f9dd;
	localparam logic [31:0] MIX_B    = 32'h4973f715;
	localparam logic [31:0] MUL_INIT = 32'h43b0d7e5;

	typedef enum logic [1:0] {
		ACT_SEED   = 2'd0,
		ACT_DRAW32 = 2'd1,
		ACT_DRAW64 = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT,
		ST_HXOR,
		ST_HMUL,
		ST_HFIN,
		ST_XMUL,
		ST_XSUB
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       seed_load;
		logic       hash_start;
		logic       hash_prod;
		logic       hash_fin;
		logic       write_src;
		logic       cross_mul;
		logic       cross_wr;
		logic       emit;
		logic       emit_last;
		logic       wide;
		logic [1:0] pos;
		logic [1:0] src;
		logic [1:0] dst;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

[sv/ssm_ctrl.sv]
// Sequencer for the seed sequence mixer: accepts items, walks the hash schedule.
// Depends on ssm_pkg; drives ssm_datapath through dp_cmd_t.
module ssm_ctrl
	import ssm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  logic [1:0]       action,
	input  logic [6:0]       count,
	output logic             cmd_stall,
	input  dp_status_t       status,
	output dp_cmd_t          cmd
);

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] rem_q;
	logic [1:0]       pos_q, src_q, dst_q;
	logic             wide_q, final_q, cross_q;

	logic             accept;
	logic [CNT_W-1:0] cnt_sat;
	logic [2:0]       dst_inc, dst_nx;
	logic             dst_done;
	logic [1:0]       src_inc, first_dst_nx;
	logic [2:0]       pos_inc;
	logic             pos_wrap, emit_go, emit_end;

	assign accept    = cmd_valid && (state_q == ST_IDLE);
	assign cmd_stall = (state_q != ST_IDLE);

	// saturate the requested count
	always_comb begin
		if (count > 7'(MAX_COUNT)) begin
			cnt_sat = CNT_W'(MAX_COUNT);
		end else begin
			cnt_sat = CNT_W'(count);
		end
	end

	// next destination word, skipping the source word
	always_comb begin
		dst_inc = {1'b0, dst_q} + 3'd1;
		if (dst_inc[1:0] == src_q && !dst_inc[2]) begin
			dst_nx = dst_inc + 3'd1;
		end else begin
			dst_nx = dst_inc;
		end
		dst_done     = dst_nx[2];
		src_inc      = src_q + 2'd1;
		first_dst_nx = (src_inc == 2'd0) ? 2'd1 : 2'd0;
	end

	// emit bookkeeping
	assign pos_inc  = {1'b0, pos_q} + (wide_q ? 3'd2 : 3'd1);
	assign pos_wrap = pos_inc[2];
	assign emit_go  = (state_q == ST_EMIT) && status.out_free;
	assign emit_end = (rem_q == CNT_W'(1)) || pos_wrap;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action_t'(action))
						ACT_SEED:               state_nx = ST_HXOR;
						ACT_DRAW32, ACT_DRAW64: state_nx = (cnt_sat == '0) ? ST_HXOR : ST_EMIT;
						default:                state_nx = ST_IDLE;
					endcase
				end
			end
			ST_EMIT: begin
				if (emit_go && emit_end) begin
					state_nx = ST_HXOR;
				end
			end
			ST_HXOR: state_nx = ST_HMUL;
			ST_HMUL: state_nx = ST_HFIN;
			ST_HFIN: state_nx = cross_q ? ST_XMUL : ST_HXOR;
			ST_XMUL: state_nx = ST_XSUB;
			ST_XSUB: begin
				if (dst_done && src_q == 2'd3) begin
					if (rem_q != '0) begin
						state_nx = ST_EMIT;
					end else if (final_q) begin
						state_nx = ST_IDLE;
					end else begin
						state_nx = ST_HXOR;
					end
				end else begin
					state_nx = ST_HXOR;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd            = '0;
		cmd.seed_load  = accept && (action_t'(action) == ACT_SEED);
		cmd.hash_start = (state_q == ST_HXOR);
		cmd.hash_prod  = (state_q == ST_HMUL);
		cmd.hash_fin   = (state_q == ST_HFIN);
		cmd.write_src  = !cross_q;
		cmd.cross_mul  = (state_q == ST_XMUL);
		cmd.cross_wr   = (state_q == ST_XSUB);
		cmd.emit       = emit_go;
		cmd.emit_last  = (rem_q == CNT_W'(1));
		cmd.wide       = wide_q;
		cmd.pos        = pos_q;
		cmd.src        = src_q;
		cmd.dst        = dst_q;
	end

	// state and schedule counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
			pos_q   <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			wide_q  <= 1'b0;
			final_q <= 1'b0;
			cross_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				ST_IDLE: begin
					src_q   <= 2'd0;
					cross_q <= 1'b0;
					pos_q   <= 2'd0;
					if (accept) begin
						wide_q <= (action_t'(action) == ACT_DRAW64);
						if (action_t'(action) == ACT_SEED) begin
							rem_q   <= '0;
							final_q <= 1'b1;
						end else begin
							rem_q   <= cnt_sat;
							final_q <= (cnt_sat == '0);
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						rem_q <= rem_q - CNT_W'(1);
						pos_q <= pos_inc[1:0];
						src_q   <= 2'd0;
						cross_q <= 1'b0;
						// a wrap needs a block update before the closing one
						final_q <= !pos_wrap;
					end
				end
				ST_HFIN: begin
					if (!cross_q) begin
						if (src_q == 2'd3) begin
							cross_q <= 1'b1;
							src_q   <= 2'd0;
							dst_q   <= 2'd1;
						end else begin
							src_q <= src_inc;
						end
					end
				end
				ST_XSUB: begin
					if (!dst_done) begin
						dst_q <= dst_nx[1:0];
					end else if (src_q != 2'd3) begin
						src_q <= src_inc;
						dst_q <= first_dst_nx;
					end else begin
						// update finished
						src_q   <= 2'd0;
						cross_q <= 1'b0;
						if (rem_q == '0) begin
							final_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[sv/ssm_datapath.sv]
// Datapath of the seed sequence mixer: mixing words, multiplier, hash pipeline,
// result register. Depends on ssm_pkg; commanded by ssm_ctrl.
module ssm_datapath
	import ssm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic [31:0] seed_word0,
	input  logic [31:0] seed_word1,
	input  logic [31:0] seed_word2,
	input  logic [31:0] seed_word3,
	input  logic        res_stall,
	output logic        res_valid,
	output logic [63:0] word,
	output logic        last
);

	logic [31:0] words_q [4];
	logic [31:0] mult_q;
	logic [31:0] xor_q, pa_q, prod_q, hash_q, pb_q;
	logic [63:0] word_q;
	logic        last_q, valid_q;

	logic [31:0] hash_fold, diff, diff_fold;
	logic [1:0]  pos_hi;

	assign hash_fold = prod_q ^ {16'h0, prod_q[31:16]};
	assign diff      = pa_q - pb_q;
	assign diff_fold = diff ^ {16'h0, diff[31:16]};
	assign pos_hi    = cmd.pos | 2'd1;

	// mixing words and hash multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '{default: 32'h0};
			mult_q  <= MUL_INIT;
		end else begin
			if (cmd.seed_load) begin
				words_q[0] <= seed_word0;
				words_q[1] <= seed_word1;
				words_q[2] <= seed_word2;
				words_q[3] <= seed_word3;
				mult_q     <= MUL_INIT;
			end
			if (cmd.hash_start) begin
				mult_q <= mult_q * MUL_STEP;
			end
			if (cmd.hash_fin && cmd.write_src) begin
				words_q[cmd.src] <= hash_fold;
			end
			if (cmd.cross_wr) begin
				words_q[cmd.dst] <= diff_fold;
			end
		end
	end

	// hash and cross-mix temporaries
	always_ff @(posedge clk) begin
		if (cmd.hash_start) begin
			xor_q <= words_q[cmd.src] ^ mult_q;
			pa_q  <= MIX_A * words_q[cmd.dst];
		end
		if (cmd.hash_prod) begin
			prod_q <= xor_q * mult_q;
		end
		if (cmd.hash_fin) begin
			hash_q <= hash_fold;
		end
		if (cmd.cross_mul) begin
			pb_q <= MIX_B * hash_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			word_q <= cmd.wide ? {words_q[pos_hi], words_q[cmd.pos]}
			                   : {32'h0, words_q[cmd.pos]};
			last_q <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign status.out_free = !valid_q || !res_stall;
	assign res_valid       = valid_q;
	assign word            = word_q;
	assign last            = last_q;

endmodule

[sv/seed_sequence_mixer.sv]
// Top level of the seed sequence mixer: controller plus datapath.
// Depends on ssm_pkg, ssm_ctrl and ssm_datapath.
//
// One item at a time: cmd_stall is high from acceptance until the item's
// work is done. Each state update is 16 hashes through one chained
// multiplier: 4 plain hashes (HXOR, HMUL, HFIN) and 12 cross-mixed ones
// (HXOR, HMUL, HFIN, XMUL, XSUB). A seed runs one state update. A draw of
// n words runs u + 1 updates, where u is the number of full blocks (n / 4
// for 32-bit, n / 2 for 64-bit draws). Action code 3 is dropped.
module seed_sequence_mixer
	import ssm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  action,
	input  logic [31:0] seed_word0,
	input  logic [31:0] seed_word1,
	input  logic [31:0] seed_word2,
	input  logic [31:0] seed_word3,
	input  logic [6:0]  count,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [63:0] word,
	output logic        last
);

	dp_cmd_t    cmd;
	dp_status_t status;

	ssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.action    (action),
		.count     (count),
		.cmd_stall (cmd_stall),
		.status    (status),
		.cmd       (cmd)
	);

	ssm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.seed_word0 (seed_word0),
		.seed_word1 (seed_word1),
		.seed_word2 (seed_word2),
		.seed_word3 (seed_word3),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.word       (word),
		.last       (last)
	);

	// at most one datapath operation per cycle
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.seed_load, cmd.hash_start, cmd.hash_prod, cmd.hash_fin,
		          cmd.cross_mul, cmd.cross_wr, cmd.emit}))
		else $error("more than one datapath operation");

	// never overwrite an item still waiting on the result side
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result register overwritten");

	// results appear only while a draw is in progress
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result without an accepted draw");

endmodule
